>>> design/efb_pkg.sv
// Shared types, constants and the CRC-32 byte update for the Ethernet frame builder.
`timescale 1ns / 1ps
`default_nettype none

package efb_pkg;

    localparam int MAC_W   = 48;
    localparam int ETYPE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 11;
    localparam int CRC_W   = 32;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam int HDR_BYTES = 14;
    localparam int FCS_BYTES = 4;
    localparam int IDX_W     = 4;
    localparam int RES_LIMIT = 64;
    localparam int RUN_W     = $clog2(RES_LIMIT);

    localparam int DEF_MAX_PAYLOAD = 1500;
    localparam int DEF_MIN_PAYLOAD = 46;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [MAC_W-1:0]   DEST_MAC_RST   = 48'h111111111111;
    localparam logic [MAC_W-1:0]   SRC_MAC_RST    = 48'h222222222222;
    localparam logic [ETYPE_W-1:0] ETHER_TYPE_RST = 16'h0800;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETHER_TYPE = 2'd2;

    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_DATA = 4'b0010,
        PH_PAD  = 4'b0100,
        PH_FCS  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              run_last;
        logic              frame_last;
        logic              oversize_error;
    } result_t;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/efb_seq.sv
// Item register and byte sequencer: header, payload, padding, FCS and frame state.
`timescale 1ns / 1ps
`default_nettype none

module efb_seq #(
    parameter int MAX_PAYLOAD = efb_pkg::DEF_MAX_PAYLOAD,
    parameter int MIN_PAYLOAD = efb_pkg::DEF_MIN_PAYLOAD
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [efb_pkg::BYTE_W-1:0]    s_payload_byte,
    input  wire logic                          s_payload_last,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [efb_pkg::MAC_W-1:0]     dest_mac,
    input  wire logic [efb_pkg::MAC_W-1:0]     src_mac,
    input  wire logic [efb_pkg::ETYPE_W-1:0]   ether_type,
    output logic                               res_valid,
    output efb_pkg::result_t                   res,
    input  wire logic                          out_ready
);
    import efb_pkg::*;

    logic                item_valid_reg, item_valid_next;
    logic [BYTE_W-1:0]   item_byte_reg;
    logic                item_last_reg;
    phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [RUN_W-1:0]    run_cnt_reg, run_cnt_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                in_frame_reg, in_frame_next;
    logic                discarding_reg, discarding_next;

    logic [HDR_BYTES*BYTE_W-1:0] hdr_word;
    logic [IDX_W-1:0]            hdr_shift;
    logic [BYTE_W-1:0]           hdr_byte;
    logic [BYTE_W-1:0]           data_byte;
    logic [BYTE_W-1:0]           fcs_byte;
    logic [CRC_W-1:0]            crc_upd;
    logic [CNT_W-1:0]            count_inc;
    logic                        step;
    logic                        done;
    logic                        trunc;

    assign hdr_word  = {dest_mac, src_mac, ether_type};
    assign hdr_shift = IDX_W'(HDR_BYTES - 1) - idx_reg;
    assign hdr_byte  = BYTE_W'(hdr_word >> {hdr_shift, 3'b000});
    assign fcs_byte  = BYTE_W'(~crc_reg >> {idx_reg[1:0], 3'b000});
    assign count_inc = count_reg + CNT_W'(1);
    assign trunc     = (run_cnt_reg == RUN_W'(RES_LIMIT - 1));
    assign step      = item_valid_reg && (discarding_reg || out_ready);

    always_comb begin
        case (phase_reg)
            PH_HDR:  data_byte = hdr_byte;
            PH_DATA: data_byte = item_byte_reg;
            default: data_byte = '0;
        endcase
    end

    assign crc_upd = crc_byte(crc_reg, data_byte);

    always_comb begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        run_cnt_next    = run_cnt_reg;
        crc_next        = crc_reg;
        count_next      = count_reg;
        in_frame_next   = in_frame_reg;
        discarding_next = discarding_reg;
        res             = '0;
        res_valid       = 1'b0;
        done            = 1'b0;

        if (step) begin
            if (discarding_reg) begin
                done = 1'b1;
                if (item_last_reg) begin
                    discarding_next = 1'b0;
                end
            end else begin
                res_valid = 1'b1;
                case (phase_reg)
                    PH_HDR: begin
                        res.frame_byte = hdr_byte;
                        crc_next       = crc_upd;
                        if (idx_reg == IDX_W'(HDR_BYTES - 1)) begin
                            phase_next    = PH_DATA;
                            idx_next      = '0;
                            in_frame_next = 1'b1;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PH_DATA: begin
                        if (count_reg >= CNT_W'(MAX_PAYLOAD)) begin
                            res.frame_last     = 1'b1;
                            res.oversize_error = 1'b1;
                            done               = 1'b1;
                            crc_next           = CRC_INIT;
                            count_next         = '0;
                            in_frame_next      = 1'b0;
                            discarding_next    = !item_last_reg;
                        end else begin
                            res.frame_byte = item_byte_reg;
                            crc_next       = crc_upd;
                            count_next     = count_inc;
                            if (!item_last_reg) begin
                                done = 1'b1;
                            end else if (count_inc < CNT_W'(MIN_PAYLOAD)) begin
                                phase_next = PH_PAD;
                            end else begin
                                phase_next = PH_FCS;
                                idx_next   = '0;
                            end
                        end
                    end
                    PH_PAD: begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(MIN_PAYLOAD)) begin
                            phase_next = PH_FCS;
                            idx_next   = '0;
                        end
                    end
                    PH_FCS: begin
                        res.frame_byte = fcs_byte;
                        if (idx_reg == IDX_W'(FCS_BYTES - 1)) begin
                            res.frame_last = 1'b1;
                            done           = 1'b1;
                            crc_next       = CRC_INIT;
                            count_next     = '0;
                            in_frame_next  = 1'b0;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase

                // A run is cut short at the result limit; the frame is then abandoned.
                if (trunc && !done) begin
                    done          = 1'b1;
                    crc_next      = CRC_INIT;
                    count_next    = '0;
                    in_frame_next = 1'b0;
                end
                res.run_last = done;
            end

            if (done) begin
                run_cnt_next = '0;
                idx_next     = '0;
                phase_next   = in_frame_next ? PH_DATA : PH_HDR;
            end else begin
                run_cnt_next = run_cnt_reg + RUN_W'(1);
            end
        end
    end

    assign s_ready         = !item_valid_reg || done;
    assign item_valid_next = (s_valid && s_ready) ? 1'b1 : (done ? 1'b0 : item_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR;
            idx_reg        <= '0;
            run_cnt_reg    <= '0;
            crc_reg        <= CRC_INIT;
            count_reg      <= '0;
            in_frame_reg   <= 1'b0;
            discarding_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            run_cnt_reg    <= run_cnt_next;
            crc_reg        <= crc_next;
            count_reg      <= count_next;
            in_frame_reg   <= in_frame_next;
            discarding_reg <= discarding_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_byte_reg <= s_payload_byte;
            item_last_reg <= s_payload_last;
        end
    end

    // Between items the sequencer rests at the start of a header or of a payload byte.
    a_rest_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid_reg |-> (idx_reg == '0) && (run_cnt_reg == '0) &&
            (phase_reg == (in_frame_reg ? PH_DATA : PH_HDR)))
        else $error("sequencer not at rest between items");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    a_discard_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg |-> !in_frame_reg && (phase_reg == PH_HDR))
        else $error("discarding while a frame is open");

    a_hdr_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HDR) |-> !in_frame_reg)
        else $error("header phase inside an open frame");

    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.oversize_error |=> !in_frame_reg && (count_reg == '0))
        else $error("frame not dropped after oversize error");

endmodule

`default_nettype wire

>>> design/efb_out.sv
// Output register between the sequencer and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module efb_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire efb_pkg::result_t  in_res,
    output logic                   in_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output efb_pkg::result_t       m_res
);
    import efb_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

`default_nettype wire

>>> design/ethernet_frame_builder.sv
// Top level of the Ethernet II frame builder: configuration registers, sequencer, output register.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_payload_byte, s_payload_last
//   m_        out        m_valid/m_ready    m_frame_byte, m_run_last, m_frame_last,
//                                           m_oversize_error
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// While m_ready is high, one result byte leaves per cycle and the sequencer updates the CRC-32
// one byte per cycle. A payload byte inside a frame yields one result byte; the first byte of
// a frame is preceded by the header, and a last byte is followed by zero padding up to
// MIN_PAYLOAD payload bytes and by the FCS; an oversize error yields one error result and a
// discarded byte yields none.
// While a header, padding or FCS run is being emitted the input is stalled; m_ready low stalls
// the output register and, behind it, the sequencer.
// Reset is synchronous on aresetn and restores the header registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_frame_builder #(
    parameter int MAX_PAYLOAD = efb_pkg::DEF_MAX_PAYLOAD,
    parameter int MIN_PAYLOAD = efb_pkg::DEF_MIN_PAYLOAD
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [efb_pkg::BYTE_W-1:0]       s_payload_byte,
    input  wire logic                             s_payload_last,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    output logic [efb_pkg::BYTE_W-1:0]            m_frame_byte,
    output logic                                  m_run_last,
    output logic                                  m_frame_last,
    output logic                                  m_oversize_error,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    input  wire logic                             cfg_we,
    input  wire logic [efb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [efb_pkg::CFG_W-1:0]        cfg_wdata
);
    import efb_pkg::*;

    logic [MAC_W-1:0]   dest_mac_reg;
    logic [MAC_W-1:0]   src_mac_reg;
    logic [ETYPE_W-1:0] ether_type_reg;

    logic    seq_valid;
    result_t seq_res;
    logic    out_ready;
    result_t out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_mac_reg   <= DEST_MAC_RST;
            src_mac_reg    <= SRC_MAC_RST;
            ether_type_reg <= ETHER_TYPE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEST_MAC:   dest_mac_reg   <= cfg_wdata[MAC_W-1:0];
                CFG_SRC_MAC:    src_mac_reg    <= cfg_wdata[MAC_W-1:0];
                CFG_ETHER_TYPE: ether_type_reg <= cfg_wdata[ETYPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    efb_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MIN_PAYLOAD (MIN_PAYLOAD)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_payload_byte (s_payload_byte),
        .s_payload_last (s_payload_last),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .dest_mac       (dest_mac_reg),
        .src_mac        (src_mac_reg),
        .ether_type     (ether_type_reg),
        .res_valid      (seq_valid),
        .res            (seq_res),
        .out_ready      (out_ready)
    );

    efb_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (seq_valid),
        .in_res   (seq_res),
        .in_ready (out_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_frame_byte     = out_res.frame_byte;
    assign m_run_last       = out_res.run_last;
    assign m_frame_last     = out_res.frame_last;
    assign m_oversize_error = out_res.oversize_error;

endmodule

`default_nettype wire

>>> bench/tb_ethernet_frame_builder.sv
// Self-checking bench for the Ethernet frame builder: random valid/ready traffic against a predictor.
`timescale 1ns / 1ps

module tb_ethernet_frame_builder;
    import efb_pkg::*;

    localparam int MAX_PAY        = DEF_MAX_PAYLOAD;
    localparam int MIN_PAY        = DEF_MIN_PAYLOAD;
    localparam int RANDOM_ITEMS   = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } payload_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [BYTE_W-1:0]    s_payload_byte = '0;
    logic                 s_payload_last = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    m_frame_byte;
    logic                 m_run_last;
    logic                 m_frame_last;
    logic                 m_oversize_error;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DEST_MAC;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    ethernet_frame_builder i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_payload_byte   (s_payload_byte),
        .s_payload_last   (s_payload_last),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_frame_byte     (m_frame_byte),
        .m_run_last       (m_run_last),
        .m_frame_last     (m_frame_last),
        .m_oversize_error (m_oversize_error),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state and its copy of the header registers.
    logic [MAC_W-1:0]   hdr_dest;
    logic [MAC_W-1:0]   hdr_src;
    logic [ETYPE_W-1:0] hdr_etype;
    logic [CRC_W-1:0]   fcs_acc;
    int unsigned        pay_count;
    logic               frame_open;
    logic               dropping;

    payload_item_t pending_items[$];
    result_t       frame_out_q[$];
    result_t       run_q[$];

    int  fail_count = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  s_gap_max = 0;
    int  m_stall_max = 0;
    int  idle_cycles = 0;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    function automatic logic [CRC_W-1:0] fcs_update(input logic [CRC_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = acc;
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0] ^ b[k]}});
        end
        return c;
    endfunction

    // Frame bytes that enter the FCS go through with_fcs; FCS and error results do not.
    task automatic emit(input logic [BYTE_W-1:0] b, input logic fl, input logic err,
                        input logic with_fcs);
        result_t r;
        if (with_fcs) begin
            fcs_acc = fcs_update(fcs_acc, b);
        end
        r.frame_byte     = b;
        r.run_last       = 1'b0;
        r.frame_last     = fl;
        r.oversize_error = err;
        run_q.push_back(r);
    endtask

    task automatic advance_framer(input logic [BYTE_W-1:0] pb, input logic pl);
        logic [CRC_W-1:0] fcs;
        run_q.delete();
        if (dropping) begin
            if (pl) begin
                dropping = 1'b0;
            end
        end else begin
            if (!frame_open) begin
                fcs_acc   = CRC_INIT;
                pay_count = 0;
                for (int i = 5; i >= 0; i--) emit(hdr_dest[8*i +: 8], 1'b0, 1'b0, 1'b1);
                for (int i = 5; i >= 0; i--) emit(hdr_src[8*i +: 8], 1'b0, 1'b0, 1'b1);
                emit(hdr_etype[15:8], 1'b0, 1'b0, 1'b1);
                emit(hdr_etype[7:0], 1'b0, 1'b0, 1'b1);
                frame_open = 1'b1;
            end
            if (pay_count >= MAX_PAY) begin
                emit('0, 1'b1, 1'b1, 1'b0);
                frame_open = 1'b0;
                pay_count  = 0;
                fcs_acc    = CRC_INIT;
                dropping   = !pl;
            end else begin
                emit(pb, 1'b0, 1'b0, 1'b1);
                pay_count++;
                if (pl) begin
                    while (pay_count < MIN_PAY) begin
                        emit('0, 1'b0, 1'b0, 1'b1);
                        pay_count++;
                    end
                    fcs = ~fcs_acc;
                    for (int i = 0; i < FCS_BYTES; i++) begin
                        emit(fcs[8*i +: 8], i == FCS_BYTES - 1, 1'b0, 1'b0);
                    end
                    frame_open = 1'b0;
                    pay_count  = 0;
                    fcs_acc    = CRC_INIT;
                end
            end
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].run_last = 1'b1;
        end
        foreach (run_q[i]) frame_out_q.push_back(run_q[i]);
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Sender: one item at a time, with a random gap after each accepted item.
    always @(negedge aclk) begin
        payload_item_t it;
        if (aresetn) begin
            if (s_valid && !in_taken) begin
                // Item still waiting for ready: hold it.
            end else if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_payload_byte <= it.data;
                s_payload_last <= it.last;
                s_valid        <= 1'b1;
                send_wait = $urandom_range(0, s_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready drops for a random number of cycles after each accepted result.
    always @(negedge aclk) begin
        if (out_taken) begin
            recv_wait = $urandom_range(0, m_stall_max);
        end
        if (recv_wait > 0) begin
            recv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                advance_framer(s_payload_byte, s_payload_last);
            end
            if (m_valid && m_ready) begin
                if (frame_out_q.size() == 0) begin
                    $error("unexpected result: frame_byte %0h", m_frame_byte);
                    fail_count++;
                end else begin
                    want = frame_out_q.pop_front();
                    check_field("frame_byte", want.frame_byte, m_frame_byte);
                    check_field("run_last", BYTE_W'(want.run_last), BYTE_W'(m_run_last));
                    check_field("frame_last", BYTE_W'(want.frame_last),
                                BYTE_W'(m_frame_last));
                    check_field("oversize_error", BYTE_W'(want.oversize_error),
                                BYTE_W'(m_oversize_error));
                end
            end
        end
        if ((aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_item(input logic [BYTE_W-1:0] b, input logic l);
        payload_item_t it;
        it.data = b;
        it.last = l;
        pending_items.push_back(it);
    endtask

    task automatic queue_frame(input int len);
        for (int i = 0; i < len; i++) begin
            queue_item(BYTE_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Waits until every queued item is taken and every expected result has come out,
    // then waits out a tail in case a discarded item is still in flight.
    // The check runs at the rising edge, where the sender's state is settled.
    task automatic drain();
        @(posedge aclk);
        while (pending_items.size() > 0 || s_valid || frame_out_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DEST_MAC:   hdr_dest  = val[MAC_W-1:0];
            CFG_SRC_MAC:    hdr_src   = val[MAC_W-1:0];
            CFG_ETHER_TYPE: hdr_etype = val[ETYPE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_header(input logic [MAC_W-1:0] d, input logic [MAC_W-1:0] s,
                                input logic [ETYPE_W-1:0] e);
        write_reg(CFG_DEST_MAC, d);
        write_reg(CFG_SRC_MAC, s);
        write_reg(CFG_ETHER_TYPE, {{(CFG_W-ETYPE_W){1'b0}}, e});
    endtask

    initial begin
        int sent;
        int len;
        int pick;
        hdr_dest   = DEST_MAC_RST;
        hdr_src    = SRC_MAC_RST;
        hdr_etype  = ETHER_TYPE_RST;
        fcs_acc    = CRC_INIT;
        pay_count  = 0;
        frame_open = 1'b0;
        dropping   = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset header, a lone byte that needs the most padding, then a short mixed frame.
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b0);
        queue_item(8'hA5, 1'b0);
        queue_item(8'h5A, 1'b1);
        drain();

        write_header('0, '0, '0);
        queue_item(8'hFF, 1'b1);
        queue_item(8'h01, 1'b0);
        queue_item(8'h80, 1'b1);
        drain();

        s_gap_max   = 11;
        m_stall_max = 11;
        write_header({MAC_W{1'b1}}, {MAC_W{1'b1}}, {ETYPE_W{1'b1}});
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b1);

        // A header change in the middle of a frame only shows in the next frame.
        queue_item(8'h3C, 1'b0);
        queue_item(8'hC3, 1'b0);
        drain();
        write_header(48'h0123456789AB, 48'hFEDCBA987654, 16'h86DD);
        queue_item(8'h7E, 1'b1);
        queue_item(8'h42, 1'b1);
        drain();

        // Random frames, mostly short, with random idling on both sides.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(1, 50);
            end else if (pick < 9) begin
                len = $urandom_range(40, 80);
            end else begin
                len = $urandom_range(80, 200);
            end
            if ($urandom_range(0, 3) == 0) begin
                s_gap_max   = $urandom_range(0, 1) ? 11 : 0;
                m_stall_max = $urandom_range(0, 1) ? 11 : 0;
            end
            queue_frame(len);
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_header(MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}),
                             ETYPE_W'($urandom));
            end
        end
        drain();

        if (frame_out_q.size() != 0) begin
            $error("%0d expected results never came", frame_out_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> ethernet_frame_builder.f
design/efb_pkg.sv
design/efb_seq.sv
design/efb_out.sv
design/ethernet_frame_builder.sv
bench/tb_ethernet_frame_builder.sv
